[rtl/slp_pkg.sv]
// ----------------------------------------------------------------------------
// slp_pkg: shared types and constants of the serial link port
// Opcodes, register reset values, read masks and bit periods.
// ----------------------------------------------------------------------------
package slp_pkg;

  typedef enum logic [2:0] {
    OP_RD_DATA = 3'd0,
    OP_RD_CTRL = 3'd1,
    OP_WR_DATA = 3'd2,
    OP_WR_CTRL = 3'd3,
    OP_TICK    = 3'd4
  } opcode_e;

  localparam int unsigned CntW = 18;
  localparam int unsigned PerW = 10;
  localparam int unsigned TickW = 16;

  localparam logic [7:0] CtrlResetCgb = 8'h7F;
  localparam logic [7:0] CtrlResetDmg = 8'h7E;
  localparam logic [7:0] ReadMaskCgb  = 8'h7C;
  localparam logic [7:0] ReadMaskDmg  = 8'h7E;
  localparam logic [7:0] StartClear   = 8'h7F;

  localparam logic [PerW-1:0] SlowPeriod = 10'd512;
  localparam logic [PerW-1:0] FastPeriod = 10'd16;
  localparam logic [3:0]      BitsPerByte = 4'd8;

  localparam int unsigned CtrlStartBit = 7;
  localparam int unsigned CtrlSpeedBit = 1;
  localparam int unsigned CtrlClkBit   = 0;

  // configuration register index
  localparam logic [0:0] RegCgbMode = 1'b0;

endpackage

[rtl/slp_req_if.sv]
// ----------------------------------------------------------------------------
// slp_req_if: request channel of the serial link port
// One beat carries a register access or a tick.
// ----------------------------------------------------------------------------
interface slp_req_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     opcode;
  logic [7:0]                     write_data;
  logic [slp_pkg::TickW-1:0]      tick_count;

  modport source (output valid, output opcode, output write_data, output tick_count,
                  input ready);
  modport sink   (input valid, input opcode, input write_data, input tick_count,
                  output ready);
endinterface

[rtl/slp_rsp_if.sv]
// ----------------------------------------------------------------------------
// slp_rsp_if: response channel of the serial link port
// One beat per request: read data and the transfer-done flag.
// ----------------------------------------------------------------------------
interface slp_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       transfer_done;

  modport source (output valid, output read_data, output transfer_done, input ready);
  modport sink   (input valid, input read_data, input transfer_done, output ready);
endinterface

[rtl/slp_alu.sv]
// ----------------------------------------------------------------------------
// slp_alu: shared counter adder
// Subtracts a tick count from, or adds the bit period to, the cycle counter.
// ----------------------------------------------------------------------------
module slp_alu (
  input  logic signed [slp_pkg::CntW-1:0]  cnt_i,
  input  logic        [slp_pkg::TickW-1:0] tick_i,
  input  logic        [slp_pkg::PerW-1:0]  period_i,
  input  logic                             sub_i,
  output logic signed [slp_pkg::CntW-1:0]  sum_o,
  output logic                             cnt_le_zero_o
);

  logic [slp_pkg::CntW-1:0] opb;

  always_comb begin
    if (sub_i) begin
      opb = ~{{(slp_pkg::CntW-slp_pkg::TickW){1'b0}}, tick_i};
    end else begin
      opb = {{(slp_pkg::CntW-slp_pkg::PerW){1'b0}}, period_i};
    end
  end

  assign sum_o         = $signed(cnt_i + opb + {{(slp_pkg::CntW-1){1'b0}}, sub_i});
  assign cnt_le_zero_o = cnt_i[slp_pkg::CntW-1] || (cnt_i == '0);

endmodule

[rtl/serial_link_port_open_line.sv]
// ----------------------------------------------------------------------------
// serial_link_port_open_line: link port with no partner attached
// Data and control byte registers plus the internal-clock transfer engine.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one beat per request: register read, register write or a
//   tick with an elapsed cycle count. rsp_o returns exactly one beat per
//   request, in order: read_data for reads (zero otherwise) and
//   transfer_done on the tick that finishes the eighth bit.
//   Register accesses and idle ticks go from accept straight to the emit
//   state. A tick while busy passes subtract, loop and emit, with one loop
//   pass per completed bit period; the pass that ends the eighth bit skips
//   the final counter check. The single counter adder does one subtract and
//   then one period add per cycle while the counter is not positive.
//   req_i.ready is high only while the sequencer is idle. A response waits
//   in the output register while rsp_o.ready is low; a finished request
//   holds in the emit state until that register is free.
//   The APB port holds cgb_mode at address 0; writing it also reloads the
//   control byte with the mode's reset value.
//   After rst_ni: data 0x00, control 0x7E, idle, slow clock, mode 0.
// ----------------------------------------------------------------------------
module serial_link_port_open_line (
  input  logic        clk_i,
  input  logic        rst_ni,
  slp_req_if.sink     req_i,
  slp_rsp_if.source   rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSub  = 2'd1;
  localparam logic [1:0] StLoop = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0] state_q, state_d;
  logic       cgb_q, cgb_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] ctrl_q, ctrl_d;
  logic       busy_q, busy_d;
  logic [3:0] bits_q, bits_d;
  logic [slp_pkg::PerW-1:0]       period_q, period_d;
  logic signed [slp_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [slp_pkg::TickW-1:0]      tick_q, tick_d;
  logic [7:0] res_rd_q, res_rd_d;
  logic       res_done_q, res_done_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_rd_q, out_rd_d;
  logic       out_done_q, out_done_d;

  logic                             alu_sub;
  logic signed [slp_pkg::CntW-1:0]  alu_sum;
  logic                             cnt_le_zero;
  logic                             req_fire;
  logic                             cfg_wr;
  logic                             out_free;
  logic [slp_pkg::PerW-1:0]         new_period;

  slp_alu u_alu (
    .cnt_i         (cnt_q),
    .tick_i        (tick_q),
    .period_i      (period_q),
    .sub_i         (alu_sub),
    .sum_o         (alu_sum),
    .cnt_le_zero_o (cnt_le_zero)
  );

  assign req_i.ready = (state_q == StIdle);
  assign req_fire    = req_i.valid && req_i.ready;
  assign alu_sub     = (state_q == StSub);
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == slp_pkg::RegCgbMode);
  assign prdata = (paddr == slp_pkg::RegCgbMode) ? {31'd0, cgb_q} : 32'd0;

  assign new_period = (cgb_q && req_i.write_data[slp_pkg::CtrlSpeedBit]) ?
                      slp_pkg::FastPeriod : slp_pkg::SlowPeriod;

  always_comb begin
    state_d     = state_q;
    cgb_d       = cgb_q;
    shift_d     = shift_q;
    ctrl_d      = ctrl_q;
    busy_d      = busy_q;
    bits_d      = bits_q;
    period_d    = period_q;
    cnt_d       = cnt_q;
    tick_d      = tick_q;
    res_rd_d    = res_rd_q;
    res_done_d  = res_done_q;
    out_valid_d = out_valid_q;
    out_rd_d    = out_rd_q;
    out_done_d  = out_done_q;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_wr) begin
      cgb_d  = pwdata[0];
      ctrl_d = pwdata[0] ? slp_pkg::CtrlResetCgb : slp_pkg::CtrlResetDmg;
    end

    case (state_q)
      StIdle: begin
        if (req_fire) begin
          res_rd_d   = 8'd0;
          res_done_d = 1'b0;
          state_d    = StEmit;
          case (req_i.opcode)
            slp_pkg::OP_RD_DATA: res_rd_d = shift_q;
            slp_pkg::OP_RD_CTRL: begin
              res_rd_d = ctrl_q | (cgb_q ? slp_pkg::ReadMaskCgb : slp_pkg::ReadMaskDmg);
            end
            slp_pkg::OP_WR_DATA: shift_d = req_i.write_data;
            slp_pkg::OP_WR_CTRL: begin
              ctrl_d = req_i.write_data;
              if (req_i.write_data[slp_pkg::CtrlStartBit] &&
                  req_i.write_data[slp_pkg::CtrlClkBit]) begin
                busy_d   = 1'b1;
                bits_d   = slp_pkg::BitsPerByte;
                period_d = new_period;
                cnt_d    = $signed({{(slp_pkg::CntW-slp_pkg::PerW){1'b0}}, new_period});
              end
            end
            slp_pkg::OP_TICK: begin
              tick_d = req_i.tick_count;
              if (busy_q) begin
                state_d = StSub;
              end
            end
            default: ;
          endcase
        end
      end
      StSub: begin
        cnt_d   = alu_sum;
        state_d = StLoop;
      end
      StLoop: begin
        if (cnt_le_zero) begin
          // one bit period elapsed: open line shifts in a 1
          shift_d = {shift_q[6:0], 1'b1};
          cnt_d   = alu_sum;
          bits_d  = bits_q - 4'd1;
          if (bits_q == 4'd1) begin
            ctrl_d     = ctrl_q & slp_pkg::StartClear;
            busy_d     = 1'b0;
            res_done_d = 1'b1;
            state_d    = StEmit;
          end
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rd_d    = res_rd_q;
          out_done_d  = res_done_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cgb_q       <= 1'b0;
      shift_q     <= 8'd0;
      ctrl_q      <= slp_pkg::CtrlResetDmg;
      busy_q      <= 1'b0;
      bits_q      <= slp_pkg::BitsPerByte;
      period_q    <= slp_pkg::SlowPeriod;
      cnt_q       <= $signed({{(slp_pkg::CntW-slp_pkg::PerW){1'b0}}, slp_pkg::SlowPeriod});
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cgb_q       <= cgb_d;
      shift_q     <= shift_d;
      ctrl_q      <= ctrl_d;
      busy_q      <= busy_d;
      bits_q      <= bits_d;
      period_q    <= period_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tick_q     <= tick_d;
    res_rd_q   <= res_rd_d;
    res_done_q <= res_done_d;
    out_rd_q   <= out_rd_d;
    out_done_q <= out_done_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.read_data     = out_rd_q;
  assign rsp_o.transfer_done = out_done_q;

endmodule
